@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL; define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define BST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BST_ASSERT(lbl, prop, msg)
`define BST_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ sv/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg
// Shared widths, operation codes and swap masks for the bitboard transform.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int BOARD_W = 64;
  localparam int OP_W    = 4;
  localparam int AMT_W   = 6;

  typedef logic [BOARD_W-1:0] board_t;
  typedef logic [AMT_W-1:0]   amt_t;

  typedef enum logic [OP_W-1:0] {
    OP_VFLIP    = 4'd0,
    OP_MIRROR   = 4'd1,
    OP_DIAG_A1  = 4'd2,
    OP_DIAG_A8  = 4'd3,
    OP_ROT180   = 4'd4,
    OP_ROT90CW  = 4'd5,
    OP_ROT90CCW = 4'd6,
    OP_P45CW    = 4'd7,
    OP_P45CCW   = 4'd8,
    OP_ROTR     = 4'd9
  } bst_op_t;

  // diagonal delta-swap masks
  localparam board_t MASK_D1_7  = 64'h5500550055005500;
  localparam board_t MASK_D1_14 = 64'h3333000033330000;
  localparam board_t MASK_D1_28 = 64'h0f0f0f0f00000000;
  localparam board_t MASK_D2_9  = 64'haa00aa00aa00aa00;
  localparam board_t MASK_D2_18 = 64'hcccc0000cccc0000;
  localparam board_t MASK_D2_36 = 64'hf0f0f0f000000000;

  // alternating bit-group masks
  localparam board_t MASK_LO1 = 64'h5555555555555555;
  localparam board_t MASK_LO2 = 64'h3333333333333333;
  localparam board_t MASK_LO4 = 64'h0f0f0f0f0f0f0f0f;
  localparam board_t MASK_HI1 = 64'haaaaaaaaaaaaaaaa;
  localparam board_t MASK_HI2 = 64'hcccccccccccccccc;
  localparam board_t MASK_HI4 = 64'hf0f0f0f0f0f0f0f0;

endpackage

@@ sv/bst_if.sv @@
// ----------------------------------------------------------------------------
// bst_if
// Valid/ready channels for board items in and transformed boards out.
// ----------------------------------------------------------------------------
interface bst_in_if;
  import bst_pkg::*;

  logic      valid;
  logic      ready;
  logic [OP_W-1:0] op;
  board_t    board_bits;
  amt_t      rotate_amount;

  modport source (output valid, output op, output board_bits, output rotate_amount,
                  input ready);
  modport sink   (input valid, input op, input board_bits, input rotate_amount,
                  output ready);
endinterface

interface bst_out_if;
  import bst_pkg::*;

  logic   valid;
  logic   ready;
  board_t result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

@@ sv/bst_xform.sv @@
// ----------------------------------------------------------------------------
// bst_xform
// Combinational permutation network: flips, mirror, rotations and
// pseudo-rotations of one 8x8 board, selected by the op code.
// ----------------------------------------------------------------------------
module bst_xform (
  input  logic [bst_pkg::OP_W-1:0] op,
  input  bst_pkg::board_t          board_bits,
  input  bst_pkg::amt_t            rotate_amount,
  output bst_pkg::board_t          result_bits
);
  import bst_pkg::*;

  function automatic board_t swap_masked(board_t x, board_t m, int unsigned d);
    board_t t;
    t = m & (x ^ (x << d));
    return x ^ t ^ (t >> d);
  endfunction

  function automatic board_t byte_reverse(board_t x);
    board_t r;
    for (int i = 0; i < 8; i++) begin
      r[8*(7-i) +: 8] = x[8*i +: 8];
    end
    return r;
  endfunction

  function automatic board_t mirror_bytes(board_t x);
    board_t y;
    y = ((x >> 1) & MASK_LO1) | ((x & MASK_LO1) << 1);
    y = ((y >> 2) & MASK_LO2) | ((y & MASK_LO2) << 2);
    y = ((y >> 4) & MASK_LO4) | ((y & MASK_LO4) << 4);
    return y;
  endfunction

  function automatic board_t diag_main(board_t x);
    board_t y;
    y = swap_masked(x, MASK_D1_28, 28);
    y = swap_masked(y, MASK_D1_14, 14);
    return swap_masked(y, MASK_D1_7, 7);
  endfunction

  function automatic board_t diag_anti(board_t x);
    board_t y;
    y = swap_masked(x, MASK_D2_36, 36);
    y = swap_masked(y, MASK_D2_18, 18);
    return swap_masked(y, MASK_D2_9, 9);
  endfunction

  // rotations by whole bytes are fixed rewiring
  function automatic board_t pseudo45(board_t x, board_t m1, board_t m2, board_t m4);
    board_t y;
    y = x ^ (m1 & (x ^ {x[7:0],  x[63:8]}));
    y = y ^ (m2 & (y ^ {y[15:0], y[63:16]}));
    return y ^ (m4 & (y ^ {y[31:0], y[63:32]}));
  endfunction

  function automatic board_t ror64(board_t x, amt_t n);
    logic [2*BOARD_W-1:0] dbl;
    dbl = {x, x} >> n;
    return dbl[BOARD_W-1:0];
  endfunction

  always_comb begin
    case (bst_op_t'(op))
      OP_VFLIP:    result_bits = byte_reverse(board_bits);
      OP_MIRROR:   result_bits = mirror_bytes(board_bits);
      OP_DIAG_A1:  result_bits = diag_main(board_bits);
      OP_DIAG_A8:  result_bits = diag_anti(board_bits);
      OP_ROT180:   result_bits = mirror_bytes(byte_reverse(board_bits));
      OP_ROT90CW:  result_bits = byte_reverse(diag_anti(board_bits));
      OP_ROT90CCW: result_bits = byte_reverse(diag_main(board_bits));
      OP_P45CW:    result_bits = pseudo45(board_bits, MASK_LO1, MASK_LO2, MASK_LO4);
      OP_P45CCW:   result_bits = pseudo45(board_bits, MASK_HI1, MASK_HI2, MASK_HI4);
      OP_ROTR:     result_bits = ror64(board_bits, rotate_amount);
      default:     result_bits = board_bits; // unused codes pass the board through
    endcase
  end

endmodule

@@ sv/bitboard_symmetry_transform.sv @@
// ----------------------------------------------------------------------------
// bitboard_symmetry_transform
// Transforms one 64-bit 8x8 bitboard per item: vertical flip, horizontal
// mirror, both diagonal flips, rotate 180, rotate 90 cw/ccw, pseudo-rotate 45
// both ways, or rotate right by rotate_amount; unused op codes return the
// board unchanged. Throughput is one item per clock unless the output stalls.
// An input register feeds a single combinational permutation network whose
// output lands in the result register, which drives out_ch.valid and
// out_ch.result_bits. in_ch.ready drops only while both registers hold items
// and out_ch.ready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitboard_symmetry_transform (
  input  logic      clk,
  input  logic      rst_n,
  bst_in_if.sink    in_ch,
  bst_out_if.source out_ch
);
  import bst_pkg::*;

  logic            s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0] s1_op_r;
  board_t          s1_board_r;
  amt_t            s1_amt_r;
  logic            out_valid_r, out_valid_nxt;
  board_t          out_result_r;
  board_t          xform_result;
  logic            out_free;
  logic            in_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_free  = !s1_valid_r || out_free;

  assign in_ch.ready        = in_free;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_bits = out_result_r;

  assign s1_valid_nxt  = in_free ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  bst_xform u_xform (
    .op            (s1_op_r),
    .board_bits    (s1_board_r),
    .rotate_amount (s1_amt_r),
    .result_bits   (xform_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_ch.valid) begin
      s1_op_r    <= in_ch.op;
      s1_board_r <= in_ch.board_bits;
      s1_amt_r   <= in_ch.rotate_amount;
    end
    if (out_free && s1_valid_r) begin
      out_result_r <= xform_result;
    end
  end

  `BST_ASSERT_ALWAYS(a_reset_clears,
    !rst_n |=> !s1_valid_r && !out_valid_r,
    "valid left set after reset")
  `BST_ASSERT(a_stall_only_full,
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready,
    "input stalled with room")
  `BST_ASSERT(a_accept_loads,
    in_ch.valid && in_ch.ready |=> s1_valid_r && s1_board_r == $past(in_ch.board_bits),
    "accepted item not in input register")
  `BST_ASSERT(a_result_moves,
    s1_valid_r && out_free |=> out_valid_r && out_result_r == $past(xform_result),
    "result register missed item")
  `BST_ASSERT(a_held_item,
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_board_r) && $stable(s1_op_r),
    "stalled item lost")

endmodule
